/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion helpers for the saliency block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

/* sv/psk_pkg.sv */
// ----------------------------------------------------------------------------
// psk_pkg
// Types, codes and fixed widths shared by the saliency controller and datapath.
// ----------------------------------------------------------------------------
package psk_pkg;

  // fixed field widths
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 24;
  localparam int DQ_W      = 16;
  localparam int OUT_W     = 16;

  // arithmetic widths
  localparam int SQD_W     = 14;  // square of a dimension or distance
  localparam int SQ_W      = 18;  // sum of squared channel differences
  localparam int D2_W      = 28;  // rows^2 * cols^2
  localparam int NUM_W     = 29;  // spatial numerator
  localparam int FRAC_BITS = 28;
  localparam int CQ_W      = 15;
  localparam int DEN_W     = 25;
  localparam int MQ_W      = 15;
  localparam int T_W       = 35;  // series term
  localparam int PROD_W    = 50;
  localparam int ACC_W     = 37;
  localparam int Q14       = 14;
  localparam int DIV_DDW   = 57;  // divider dividend / quotient
  localparam int DIV_DVW   = 28;  // divider divisor
  localparam int SQ_IW     = 46;  // root radicand
  localparam int ROOT_W    = SQ_IW / 2;
  localparam int EXP_TERMS = 24;
  localparam int N_W       = 5;

  // divide the color root by 255: ceil(2^31 / 255), exact for roots below 2^24
  localparam int RECIP_W   = 24;
  localparam int CQ_RECIP  = 8421505;
  localparam int CQ_SHIFT  = 31;
  localparam int CQP_W     = ROOT_W + RECIP_W;

  localparam int ONE_Q14   = 16384;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ZERO, ST_QRD, ST_QLD, ST_PRD, ST_PLD, ST_NUM, ST_CSQ,
    ST_XDIV, ST_XSQ, ST_DEN, ST_DDIV, ST_SUM, ST_MDIV, ST_EMUL,
    ST_ESTART, ST_EDIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DS_SPACE, DS_DIST, DS_MEAN, DS_EXP
  } div_sel_t;

  typedef enum logic {
    SS_COLOR, SS_SPACE
  } sq_sel_t;

  typedef struct packed {
    logic     load_wr;
    logic     q_latch;
    logic     rd_query;
    logic     ld_qpix;
    logic     rd_pix;
    logic     ld_prod;
    logic     ld_num;
    logic     sqrt_start;
    sq_sel_t  sqrt_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     ld_cq;
    logic     ld_den;
    logic     insert;
    logic     sum_step;
    logic     ld_mq;
    logic     ld_eprod;
    logic     ld_term;
    logic     out_strobe;
    logic     out_zero;
  } cmd_t;

  typedef struct packed {
    logic q_in_store;
    logic div_done;
    logic sqrt_done;
    logic last_pix;
    logic sum_done;
    logic last_term;
  } sts_t;

endpackage

/* sv/psk_ram.sv */
// ----------------------------------------------------------------------------
// psk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/psk_div.sv */
// ----------------------------------------------------------------------------
// psk_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psk_div #(
  parameter int DDW = 57,
  parameter int DVW = 28
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DDW-1:0] quo
);

  localparam int CW = $clog2(DDW + 1);

  logic [CW-1:0]  cnt_r;
  logic           done_r;
  logic [DDW-1:0] quo_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dvs_r;
  logic [DVW:0]   rem_sh;
  logic           q_bit;
  logic [DVW-1:0] rem_nxt;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, quo_r[DDW-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = q_bit ? DVW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVW-1:0];
  end

  // iterate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
        cnt_r <= CW'(DDW);
      end else if (cnt_r != '0) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DDW-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* sv/psk_sqrt.sv */
// ----------------------------------------------------------------------------
// psk_sqrt
// Exact integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module psk_sqrt #(
  parameter int IW = 46
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IW-1:0]     radicand,
  output logic              done,
  output logic [IW/2-1:0]   root
);

  localparam int NIT = IW / 2;
  localparam int CW  = $clog2(NIT + 1);

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [IW-1:0] v_r;
  logic [IW-1:0] res_r;
  logic [IW-1:0] bit_r;
  logic [IW:0]   trial;
  logic          ge;

  // compare remainder with res + bit
  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    ge    = ({1'b0, v_r} >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= radicand;
        res_r <= '0;
        bit_r <= IW'(1) << (IW - 2);
        cnt_r <= CW'(NIT);
      end else if (cnt_r != '0) begin
        if (ge) begin
          v_r   <= IW'({1'b0, v_r} - trial);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[IW/2-1:0];

endmodule

/* sv/psk_datapath.sv */
// ----------------------------------------------------------------------------
// psk_datapath
// Pixel store, distance arithmetic, sorted nearest list and exp series.
// ----------------------------------------------------------------------------
module psk_datapath #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int NEIGHBORS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psk_pkg::cmd_t          cmd,
  output psk_pkg::sts_t          sts,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [6:0]             cfg_data,
  input  logic [5:0]             in_pixel_row,
  input  logic [5:0]             in_pixel_col,
  input  logic [7:0]             in_chan_l,
  input  logic [7:0]             in_chan_a,
  input  logic [7:0]             in_chan_b,
  output logic                   out_valid,
  output logic [15:0]            out_saliency
);
  import psk_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KEEP  = NEIGHBORS + 1;
  localparam int KW    = $clog2(KEEP + 1);
  localparam int SW    = DQ_W + KW;

  // configuration
  logic [DIM_W-1:0] image_rows_r, image_cols_r;
  // query setup
  logic [COORD_W-1:0] qr_r, qc_r;
  logic [DIM_W-1:0]   dim_rows_r, dim_cols_r;
  logic [SQD_W-1:0]   rows_sq_r, cols_sq_r;
  logic [D2_W-1:0]    d2_r;
  logic [PIX_W-1:0]   qpix_r;
  // walk
  logic [DIM_W-1:0]   r_r, c_r;
  logic [SQD_W-1:0]   drsq_r, dcsq_r;
  logic [SQ_W-1:0]    sq_r;
  logic [D2_W-1:0]    t1_r, t2_r;
  logic [NUM_W-1:0]   num_r;
  logic [CQ_W-1:0]    cq_r;
  logic [DEN_W-1:0]   den_r;
  // nearest list
  logic [DQ_W-1:0]    list_r   [KEEP];
  logic               vld_r    [KEEP];
  logic [DQ_W-1:0]    list_nxt [KEEP];
  logic               vld_nxt  [KEEP];
  logic               gt       [KEEP];
  logic [KW-1:0]      kept_r;
  logic [SW-1:0]      sum_r;
  // series
  logic [MQ_W-1:0]    mq_r;
  logic [T_W-1:0]     t_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   pos_r, neg_r;
  logic [N_W-1:0]     n_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_sal_r;

  // shared units
  logic [DIV_DDW-1:0] div_dividend, div_quo;
  logic [DIV_DVW-1:0] div_divisor;
  logic               div_done;
  logic [SQ_IW-1:0]   sq_radicand;
  logic [ROOT_W-1:0]  sq_root;
  logic               sq_done;

  // memory signals
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [PIX_W-1:0]   ram_rdata;
  logic               q_in_store;

  // misc comb
  logic [DIM_W-1:0]   dr, dc;
  logic [CH_W-1:0]    dl, da, db;
  logic [DQ_W-1:0]    dq;
  logic [CQP_W-1:0]   cq_prod;
  logic [ACC_W-1:0]   e_raw;
  logic [32:0]        e_cl;
  logic [16:0]        s_full;
  logic [OUT_W-1:0]   sal;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int mx);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > mx) begin
      res = DIM_W'(mx);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [CH_W-1:0] absdiff8(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // store
  assign q_in_store = (32'(in_pixel_row) < MAX_ROWS) && (32'(in_pixel_col) < MAX_COLS);
  assign ram_we     = cmd.load_wr && q_in_store;
  assign ram_waddr  = AW'(32'(in_pixel_row) * MAX_COLS + 32'(in_pixel_col));
  assign ram_re     = cmd.rd_query || cmd.rd_pix;
  assign ram_raddr  = cmd.rd_query ? AW'(32'(qr_r) * MAX_COLS + 32'(qc_r))
                                   : AW'(32'(r_r) * MAX_COLS + 32'(c_r));

  psk_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_chan_l, in_chan_a, in_chan_b}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // select divider operands
  always_comb begin
    case (cmd.div_sel)
      DS_SPACE: begin
        div_dividend = {num_r, {FRAC_BITS{1'b0}}};
        div_divisor  = d2_r;
      end
      DS_DIST: begin
        div_dividend = DIV_DDW'({cq_r, {Q14{1'b0}}});
        div_divisor  = DIV_DVW'(den_r);
      end
      DS_MEAN: begin
        div_dividend = DIV_DDW'(sum_r);
        div_divisor  = DIV_DVW'(kept_r);
      end
      DS_EXP: begin
        div_dividend = DIV_DDW'(prod_r >> Q14);
        div_divisor  = DIV_DVW'(n_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_DVW'(1);
      end
    endcase
  end

  psk_div #(.DDW(DIV_DDW), .DVW(DIV_DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo)
  );

  // select root operand
  assign sq_radicand = (cmd.sqrt_sel == SS_COLOR) ? {sq_r, {FRAC_BITS{1'b0}}}
                                                  : div_quo[SQ_IW-1:0];

  psk_sqrt #(.IW(SQ_IW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  // color root over 255 by reciprocal multiplication
  assign cq_prod = CQP_W'(sq_root) * CQP_W'(CQ_RECIP);

  // distances to the current pixel
  assign dr = ({1'b0, qr_r} > r_r) ? ({1'b0, qr_r} - r_r) : (r_r - {1'b0, qr_r});
  assign dc = ({1'b0, qc_r} > c_r) ? ({1'b0, qc_r} - c_r) : (c_r - {1'b0, qc_r});
  assign dl = absdiff8(qpix_r[23:16], ram_rdata[23:16]);
  assign da = absdiff8(qpix_r[15:8], ram_rdata[15:8]);
  assign db = absdiff8(qpix_r[7:0], ram_rdata[7:0]);
  assign dq = div_quo[DQ_W-1:0];

  // clear on a new query, insert into sorted list, or shift out while summing
  always_comb begin
    for (int i = 0; i < KEEP; i++) begin
      gt[i] = !vld_r[i] || (list_r[i] > dq);
    end
    for (int i = 0; i < KEEP; i++) begin
      list_nxt[i] = list_r[i];
      vld_nxt[i]  = vld_r[i];
      if (cmd.ld_qpix) begin
        vld_nxt[i] = 1'b0;
      end else if (cmd.insert && gt[i]) begin
        if (i == 0) begin
          list_nxt[i] = dq;
          vld_nxt[i]  = 1'b1;
        end else if (!gt[i-1]) begin
          list_nxt[i] = dq;
          vld_nxt[i]  = 1'b1;
        end else begin
          list_nxt[i] = list_r[i-1];
          vld_nxt[i]  = vld_r[i-1];
        end
      end else if (cmd.sum_step) begin
        if (i == KEEP - 1) begin
          vld_nxt[i] = 1'b0;
        end else begin
          list_nxt[i] = list_r[i+1];
          vld_nxt[i]  = vld_r[i+1];
        end
      end
    end
  end

  // final saliency
  always_comb begin
    e_raw  = (pos_r > neg_r) ? (pos_r - neg_r) : '0;
    e_cl   = (e_raw > ACC_W'(64'h1_0000_0000)) ? 33'h1_0000_0000 : e_raw[32:0];
    s_full = 17'((33'h1_0000_0000 - e_cl) >> 16);
    sal    = s_full[16] ? 16'hFFFF : s_full[15:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r <= DIM_W'(64);
      image_cols_r <= DIM_W'(64);
      out_valid_r  <= 1'b0;
      for (int i = 0; i < KEEP; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          image_rows_r <= cfg_data;
        end else begin
          image_cols_r <= cfg_data;
        end
      end
      out_valid_r <= cmd.out_strobe;
      for (int i = 0; i < KEEP; i++) begin
        vld_r[i] <= vld_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP; i++) begin
      list_r[i] <= list_nxt[i];
    end
    if (cmd.q_latch) begin
      qr_r       <= in_pixel_row;
      qc_r       <= in_pixel_col;
      dim_rows_r <= clamp_dim(image_rows_r, MAX_ROWS);
      dim_cols_r <= clamp_dim(image_cols_r, MAX_COLS);
    end
    if (cmd.rd_query) begin
      rows_sq_r <= SQD_W'(dim_rows_r) * SQD_W'(dim_rows_r);
      cols_sq_r <= SQD_W'(dim_cols_r) * SQD_W'(dim_cols_r);
    end
    if (cmd.ld_qpix) begin
      d2_r   <= D2_W'(rows_sq_r) * D2_W'(cols_sq_r);
      qpix_r <= ram_rdata;
      r_r    <= '0;
      c_r    <= '0;
      kept_r <= '0;
      sum_r  <= '0;
    end
    if (cmd.rd_pix) begin
      drsq_r <= SQD_W'(dr) * SQD_W'(dr);
      dcsq_r <= SQD_W'(dc) * SQD_W'(dc);
    end
    if (cmd.ld_prod) begin
      sq_r <= SQ_W'(dl * dl) + SQ_W'(da * da) + SQ_W'(db * db);
      t1_r <= D2_W'(drsq_r) * D2_W'(cols_sq_r);
      t2_r <= D2_W'(dcsq_r) * D2_W'(rows_sq_r);
    end
    if (cmd.ld_num) begin
      num_r <= NUM_W'(t1_r) + NUM_W'(t2_r);
    end
    if (cmd.ld_cq) begin
      cq_r <= cq_prod[CQ_SHIFT +: CQ_W];
    end
    if (cmd.ld_den) begin
      den_r <= DEN_W'(ONE_Q14) + DEN_W'({sq_root, 1'b0}) + DEN_W'(sq_root);
    end
    // advance the walk
    if (cmd.insert) begin
      if (32'(kept_r) < KEEP) begin
        kept_r <= kept_r + 1'b1;
      end
      if (c_r == dim_cols_r - 1'b1) begin
        c_r <= '0;
        r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    if (cmd.sum_step) begin
      sum_r <= sum_r + SW'(list_r[0]);
    end
    // series
    if (cmd.ld_mq) begin
      mq_r  <= div_quo[MQ_W-1:0];
      t_r   <= T_W'(64'h1_0000_0000);
      pos_r <= ACC_W'(64'h1_0000_0000);
      neg_r <= '0;
      n_r   <= N_W'(1);
    end
    if (cmd.ld_eprod) begin
      prod_r <= PROD_W'(t_r) * PROD_W'(mq_r);
    end
    if (cmd.ld_term) begin
      t_r <= div_quo[T_W-1:0];
      if (n_r[0]) begin
        neg_r <= neg_r + ACC_W'(div_quo[T_W-1:0]);
      end else begin
        pos_r <= pos_r + ACC_W'(div_quo[T_W-1:0]);
      end
      n_r <= n_r + 1'b1;
    end
    if (cmd.out_strobe) begin
      out_sal_r <= cmd.out_zero ? '0 : sal;
    end
  end

  // status
  assign sts.q_in_store = q_in_store;
  assign sts.div_done   = div_done;
  assign sts.sqrt_done  = sq_done;
  assign sts.last_pix   = (r_r == dim_rows_r - 1'b1) && (c_r == dim_cols_r - 1'b1);
  assign sts.sum_done   = !vld_r[0];
  assign sts.last_term  = (n_r == N_W'(EXP_TERMS));

  assign out_valid    = out_valid_r;
  assign out_saliency = out_sal_r;

endmodule

/* sv/psk_ctrl.sv */
// ----------------------------------------------------------------------------
// psk_ctrl
// Sequencer for loads, the per-pixel distance walk, the mean and the series.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           action,
  input  psk_pkg::sts_t  sts,
  output psk_pkg::cmd_t  cmd,
  output logic           busy
);
  import psk_pkg::*;

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.q_latch = 1'b1;
            state_nxt   = sts.q_in_store ? ST_QRD : ST_ZERO;
          end
        end
      end
      ST_ZERO: begin
        cmd.out_strobe = 1'b1;
        cmd.out_zero   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_QRD: begin
        cmd.rd_query = 1'b1;
        state_nxt    = ST_QLD;
      end
      ST_QLD: begin
        cmd.ld_qpix = 1'b1;
        state_nxt   = ST_PRD;
      end
      ST_PRD: begin
        cmd.rd_pix = 1'b1;
        state_nxt  = ST_PLD;
      end
      ST_PLD: begin
        cmd.ld_prod = 1'b1;
        state_nxt   = ST_NUM;
      end
      ST_NUM: begin
        cmd.ld_num     = 1'b1;
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_sel   = SS_COLOR;
        state_nxt      = ST_CSQ;
      end
      ST_CSQ: begin
        if (sts.sqrt_done) begin
          cmd.ld_cq     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_SPACE;
          state_nxt     = ST_XDIV;
        end
      end
      ST_XDIV: begin
        cmd.sqrt_sel = SS_SPACE;
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_XSQ;
        end
      end
      ST_XSQ: begin
        if (sts.sqrt_done) begin
          cmd.ld_den = 1'b1;
          state_nxt  = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_DIST;
        state_nxt     = ST_DDIV;
      end
      ST_DDIV: begin
        if (sts.div_done) begin
          cmd.insert = 1'b1;
          state_nxt  = sts.last_pix ? ST_SUM : ST_PRD;
        end
      end
      ST_SUM: begin
        if (!sts.sum_done) begin
          cmd.sum_step = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_MEAN;
          state_nxt     = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (sts.div_done) begin
          cmd.ld_mq = 1'b1;
          state_nxt = ST_EMUL;
        end
      end
      ST_EMUL: begin
        cmd.ld_eprod = 1'b1;
        state_nxt    = ST_ESTART;
      end
      ST_ESTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_EXP;
        state_nxt     = ST_EDIV;
      end
      ST_EDIV: begin
        if (sts.div_done) begin
          cmd.ld_term = 1'b1;
          state_nxt   = sts.last_term ? ST_OUT : ST_EMUL;
        end
      end
      ST_OUT: begin
        cmd.out_strobe = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  `ASSERT_IMPLIES(a_load_idle, clk, rst_n, cmd.load_wr, state_r == ST_IDLE)
  `ASSERT_IMPLIES(a_one_unit, clk, rst_n, cmd.div_start, !cmd.sqrt_start)
  `ASSERT_NEXT(a_query_go, clk, rst_n, cmd.q_latch, state_r == ST_QRD || state_r == ST_ZERO)
  `ASSERT_NEXT(a_out_idle, clk, rst_n, cmd.out_strobe, state_r == ST_IDLE)

endmodule

/* sv/pixel_saliency_knn.sv */
// ----------------------------------------------------------------------------
// pixel_saliency_knn
// Context-aware saliency of one stored pixel over its nearest neighbors.
// ----------------------------------------------------------------------------
// A load is accepted while idle; busy stays low and the next request may follow.
// A query holds busy through the distance walk, the mean and the series,
// and its result strobe follows; the bit-serial divider and root set the pixel time.
// A query outside the store returns saliency 0 through ST_ZERO and the registered out_valid.
// The result strobe out_valid lasts one cycle; the receiver cannot stall.
// Reset clears control state and sets both dimension registers to 64.
module pixel_saliency_knn #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int NEIGHBORS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_pixel_row,
  input  logic [5:0]  in_pixel_col,
  input  logic [7:0]  in_chan_l,
  input  logic [7:0]  in_chan_a,
  input  logic [7:0]  in_chan_b,
  output logic        out_valid,
  output logic [15:0] out_saliency,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import psk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  psk_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // arithmetic and storage
  psk_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .NEIGHBORS (NEIGHBORS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .in_chan_l    (in_chan_l),
    .in_chan_a    (in_chan_a),
    .in_chan_b    (in_chan_b),
    .out_valid    (out_valid),
    .out_saliency (out_saliency)
  );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_saliency_knn: loads Lab pixels, sets the
// image size and queries saliency, comparing every result with a predictor.
// ----------------------------------------------------------------------------

// Predict saliency of each query and check results in order
class saliency_scoreboard;
  bit [23:0]   pixel_mem [4096];
  int unsigned rows_reg = 64;
  int unsigned cols_reg = 64;
  bit [15:0]   saliency_due [$];
  int unsigned errors = 0;

  function longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function int unsigned active_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function int unsigned chan_diff(int unsigned x, int unsigned y);
    return (x > y) ? x - y : y - x;
  endfunction

  // Series of exp(-mq), then one minus it in Q0.16
  function bit [15:0] one_minus_exp(int unsigned mq);
    longint unsigned t, pos, neg, e, s;
    int n;
    mq &= 32'h7FFF;
    t = 64'd1 << 32;
    pos = t;
    neg = 0;
    for (n = 1; n <= 24; n++) begin
      t = (t * mq) / (64'(n) << 14);
      if (n % 2 == 1) neg += t;
      else pos += t;
    end
    e = (pos > neg) ? pos - neg : 0;
    if (e > (64'd1 << 32)) e = 64'd1 << 32;
    s = ((64'd1 << 32) - e) >> 16;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function bit [15:0] saliency_of(int unsigned qr, int unsigned qc);
    int unsigned     rows, cols, kept, sum, r, c, mq;
    longint unsigned d2, num, q, rem, sq, cq, xq, dq, dr, dc, dl, da, db;
    bit [23:0]       qp, p;
    int unsigned     dists [$];
    int              k;
    rows = active_dim(rows_reg);
    cols = active_dim(cols_reg);
    qp = pixel_mem[qr * 64 + qc];
    d2 = longint'(rows) * rows * cols * cols;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        p = pixel_mem[r * 64 + c];
        dl = chan_diff(qp[23:16], p[23:16]);
        da = chan_diff(qp[15:8], p[15:8]);
        db = chan_diff(qp[7:0], p[7:0]);
        sq = dl * dl + da * da + db * db;
        cq = int_root(sq << 28) / 255;
        dr = chan_diff(qr, r);
        dc = chan_diff(qc, c);
        num = dr * dr * cols * cols + dc * dc * rows * rows;
        q = num / d2;
        rem = num % d2;
        for (k = 0; k < 28; k++) begin
          rem <<= 1;
          q <<= 1;
          if (rem >= d2) begin
            rem -= d2;
            q |= 1;
          end
        end
        xq = int_root(q);
        dq = (cq << 14) / (16384 + 3 * xq);
        dists.insert(dists.size(), dq[31:0]);
      end
    end
    dists.sort();
    kept = (rows * cols < 65) ? rows * cols : 65;
    sum = 0;
    for (k = 0; k < kept; k++) sum += dists[k];
    mq = sum / kept;
    return one_minus_exp(mq);
  endfunction

  function void set_dim(bit index, bit [6:0] value);
    if (index == psk_pkg::CFG_ROWS) rows_reg = 32'(value);
    else cols_reg = 32'(value);
  endfunction

  function void note_request(bit action, bit [5:0] row, bit [5:0] col,
                             bit [7:0] l, bit [7:0] a, bit [7:0] b);
    if (action == psk_pkg::ACT_LOAD) pixel_mem[row * 64 + col] = {l, a, b};
    else saliency_due.insert(saliency_due.size(), saliency_of(32'(row), 32'(col)));
  endfunction

  function void check_result(bit [15:0] got);
    bit [15:0] want;
    if (saliency_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected saliency %0d", got);
      return;
    end
    want = saliency_due.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("saliency mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module testbench;
  import psk_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_action;
  logic [5:0] in_pixel_row;
  logic [5:0] in_pixel_col;
  logic [7:0] in_chan_l;
  logic [7:0] in_chan_a;
  logic [7:0] in_chan_b;
  logic       out_valid;
  logic [15:0] out_saliency;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  saliency_scoreboard sb = new();
  int  cycles = 0;
  bit  gaps_on = 1;

  pixel_saliency_knn uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .in_chan_l(in_chan_l), .in_chan_a(in_chan_a), .in_chan_b(in_chan_b),
    .out_valid(out_valid), .out_saliency(out_saliency),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count cycles and abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_saliency);
  end

  // Present one request and hold it until accepted
  task automatic send_item(bit action, bit [5:0] row, bit [5:0] col,
                           bit [7:0] l, bit [7:0] a, bit [7:0] b);
    start <= 1'b1;
    in_action <= action;
    in_pixel_row <= row;
    in_pixel_col <= col;
    in_chan_l <= l;
    in_chan_a <= a;
    in_chan_b <= b;
    do @(posedge clk); while (busy);
    sb.note_request(action, row, col, l, a, b);
  endtask

  task automatic rest_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) rest_cycles($urandom_range(1, 16));
  endtask

  task automatic load_pixel(bit [5:0] row, bit [5:0] col);
    maybe_gap();
    send_item(ACT_LOAD, row, col, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic query_pixel(bit [5:0] row, bit [5:0] col);
    maybe_gap();
    send_item(ACT_QUERY, row, col, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // Drain all results, let a trailing load settle, then set the image size
  task automatic write_dims(bit [6:0] rows, bit [6:0] cols);
    start <= 1'b0;
    while (sb.saliency_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data <= cols;
    sb.set_dim(CFG_ROWS, rows);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dim(CFG_COLS, cols);
  endtask

  initial begin
    int i, j, ph;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_LOAD;
    in_pixel_row <= '0;
    in_pixel_col <= '0;
    in_chan_l <= '0;
    in_chan_a <= '0;
    in_chan_b <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROWS;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tall image: column 0, with extreme and repeated colors
    write_dims(7'd64, 7'd1);
    send_item(ACT_LOAD, 6'd0, 6'd0, 8'd0, 8'd0, 8'd0);
    send_item(ACT_LOAD, 6'd1, 6'd0, 8'd255, 8'd255, 8'd255);
    send_item(ACT_LOAD, 6'd2, 6'd0, 8'd255, 8'd0, 8'd255);
    send_item(ACT_LOAD, 6'd3, 6'd0, 8'd0, 8'd0, 8'd0);
    for (i = 4; i < 64; i++) load_pixel(6'(i), 6'd0);
    query_pixel(6'd0, 6'd0);
    query_pixel(6'd63, 6'd0);
    query_pixel(6'd1, 6'd0);

    // Out-of-range row count acts as the limit
    write_dims(7'd127, 7'd0);
    query_pixel(6'd17, 6'd0);

    // Fill the 4x4 corner used by the random phases
    for (i = 0; i < 4; i++)
      for (j = 1; j < 4; j++) load_pixel(6'(i), 6'(j));
    write_dims(7'd0, 7'd3);
    query_pixel(6'd0, 6'd2);
    write_dims(7'd1, 7'd1);
    query_pixel(6'd3, 6'd3);
    query_pixel(6'd0, 6'd0);

    // Random phases; the last one runs without gaps
    for (ph = 0; ph < 4; ph++) begin
      if (ph == 3) gaps_on = 0;
      write_dims(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
      for (i = 0; i < 14; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 4) == 0)
            load_pixel(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
          else
            load_pixel(6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)));
        end else begin
          if ($urandom_range(0, 3) == 0)
            query_pixel(6'($urandom_range(0, 63)), 6'd0);
          else
            query_pixel(6'($urandom_range(0, 3)), 6'($urandom_range(0, 3)));
        end
      end
    end

    // Drain and report
    start <= 1'b0;
    while (sb.saliency_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
